[rtl/core/mbet_pkg.sv]
// mbet_pkg: shared constants, microcode word layout, microprogram table and
// saturation helper for the mandelbrot escape-time core. no dependencies.
`timescale 1ns / 1ps

package mbet_pkg;

    localparam int unsigned PIXEL_DIM = 4096;
    localparam int unsigned IDX_W     = 12;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned STEP_W    = 31;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned SAT_W     = 48;
    localparam int unsigned UPC_W     = 4;
    localparam int unsigned CFG_IDX_W = 3;

    // escape threshold 4.0 in q4.28, compared against a 33-bit sum
    localparam logic signed [DATA_W:0] ESC_LIMIT = (DATA_W + 1)'(4) <<< FRAC_BITS;

    localparam logic signed [DATA_W-1:0] WINDOW_X_MIN_RST = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] WINDOW_Y_MIN_RST = -32'sd300647711;
    localparam logic [STEP_W-1:0]        STEP_X_RST       = 31'd161913;
    localparam logic [STEP_W-1:0]        STEP_Y_RST       = 31'd146837;
    localparam logic [CNT_W-1:0]         MAX_ITER_RST     = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd4;

    typedef logic [UPC_W-1:0] upc_t;

    // microprogram step addresses
    localparam upc_t S_IDLE = 4'd0;
    localparam upc_t S_MCX  = 4'd1;
    localparam upc_t S_MCY  = 4'd2;
    localparam upc_t S_CY   = 4'd3;
    localparam upc_t S_LOOP = 4'd4;
    localparam upc_t S_Y    = 4'd5;
    localparam upc_t S_X2   = 4'd6;
    localparam upc_t S_Y2   = 4'd7;
    localparam upc_t S_DONE = 4'd8;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_COLX,
        MUL_ROWY,
        MUL_XY,
        MUL_XX,
        MUL_YY
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_CX,
        WB_CY,
        WB_Y,
        WB_X2,
        WB_Y2
    } wb_sel_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_EXIT,
        SEQ_WAIT_IN,
        SEQ_EMIT
    } seq_op_t;

    typedef struct packed {
        seq_op_t  op;
        upc_t     target;
        mul_sel_t mul;
        wb_sel_t  wb;
        logic     upd_x;
        logic     init;
        logic     cnt_inc;
    } ucode_t;

    typedef struct packed {
        logic exit_loop;
    } dp_status_t;

    typedef struct packed {
        logic in_ready;
        logic in_take;
        logic out_load;
    } seq_evt_t;

    // microprogram rom
    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t w;
        w = '{op: SEQ_NEXT, target: S_IDLE, mul: MUL_NONE, wb: WB_NONE,
              upd_x: 1'b0, init: 1'b0, cnt_inc: 1'b0};
        unique case (upc)
            S_IDLE: w.op = SEQ_WAIT_IN;
            S_MCX:
            begin
                w.mul  = MUL_COLX;
                w.init = 1'b1;
            end
            S_MCY:
            begin
                w.mul = MUL_ROWY;
                w.wb  = WB_CX;
            end
            S_CY: w.wb = WB_CY;
            S_LOOP:
            begin
                w.op     = SEQ_EXIT;
                w.target = S_DONE;
                w.mul    = MUL_XY;
                w.upd_x  = 1'b1;
            end
            S_Y:
            begin
                w.wb  = WB_Y;
                w.mul = MUL_XX;
            end
            S_X2:
            begin
                w.wb  = WB_X2;
                w.mul = MUL_YY;
            end
            S_Y2:
            begin
                w.wb      = WB_Y2;
                w.cnt_inc = 1'b1;
                w.op      = SEQ_JUMP;
                w.target  = S_LOOP;
            end
            S_DONE:
            begin
                w.op     = SEQ_EMIT;
                w.target = S_IDLE;
            end
            default:
            begin
                w.op     = SEQ_JUMP;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // clip a wide signed value to the q4.28 range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] hi;
        hi = v[SAT_W-1:DATA_W-1];
        if ((&hi) || !(|hi))
            return v[DATA_W-1:0];
        else if (v[SAT_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

[rtl/core/mbet_ifs.sv]
// mbet_ifs: valid/ready channel interfaces for pixel beats and result beats.
// depends on mbet_pkg.
`timescale 1ns / 1ps

interface mbet_pixel_if import mbet_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink (input valid, input column, input row, output ready);
endinterface

interface mbet_result_if import mbet_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] remaining_count;

    modport source (output valid, output remaining_count, input ready);
    modport sink (input valid, input remaining_count, output ready);
endinterface

[rtl/core/mandelbrot_escape_time_core.sv]
// mandelbrot_escape_time_core: top level with configuration registers,
// result register, microcode sequencer and datapath. depends on mbet_pkg,
// mbet_ifs, mbet_sequencer and mbet_datapath.
`timescale 1ns / 1ps

// escape-time engine for one pixel at a time. a pixel beat (column, row) is
// mapped to c = window minimum + index * step in q4.28 and z = z*z + c is
// iterated from zero until |z|^2 exceeds 4 or max_iterations steps are done;
// the result beat carries max_iterations minus the steps done. indices past
// the pixel grid are clamped, and all sums and products saturate. a single
// shared 32x32 multiplier serves x*y, x*x and y*y, so each iteration
// is four microcode steps; an item also takes the accepting step, three
// setup steps for c, one final loop test and one emit step. the emit step
// holds for as long as an earlier result still waits in the output
// register; otherwise the result sits there on its own and the next pixel
// is accepted while it waits.
// configuration must be written only while the core is idle; the core
// itself does not enforce this.

module mandelbrot_escape_time_core import mbet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    mbet_pixel_if.sink           pixel,
    mbet_result_if.source        result
);

    // configuration registers
    logic signed [DATA_W-1:0] window_x_min_reg;
    logic signed [DATA_W-1:0] window_y_min_reg;
    logic [STEP_W-1:0]        step_x_reg;
    logic [STEP_W-1:0]        step_y_reg;
    logic [CNT_W-1:0]         max_iterations_reg;

    // output register, decouples the result beat from the sequencer
    logic                     result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]         remaining_reg;

    ucode_t                   ctrl;
    seq_evt_t                 evt;
    dp_status_t               status;
    logic [CNT_W-1:0]         remaining_count;
    logic                     out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_x_min_reg   <= WINDOW_X_MIN_RST;
            window_y_min_reg   <= WINDOW_Y_MIN_RST;
            step_x_reg         <= STEP_X_RST;
            step_y_reg         <= STEP_Y_RST;
            max_iterations_reg <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            // indices past the register list are dropped
            unique case (cfg_index)
                CFG_WINDOW_X_MIN: window_x_min_reg   <= cfg_data;
                CFG_WINDOW_Y_MIN: window_y_min_reg   <= cfg_data;
                CFG_STEP_X:       step_x_reg         <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:       step_y_reg         <= cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:     max_iterations_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // slot is free when empty or when the waiting beat leaves this cycle
    assign out_free = !result_valid_reg || result.ready;

    mbet_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .evt      (evt)
    );

    mbet_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .capture         (evt.in_take),
        .column          (pixel.column),
        .row             (pixel.row),
        .window_x_min    (window_x_min_reg),
        .window_y_min    (window_y_min_reg),
        .step_x          (step_x_reg),
        .step_y          (step_y_reg),
        .max_iterations  (max_iterations_reg),
        .status          (status),
        .remaining_count (remaining_count)
    );

    assign pixel.ready = evt.in_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (evt.out_load)
            result_valid_next = 1'b1;
        else if (result.ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (evt.out_load)
            remaining_reg <= remaining_count;
    end

    assign result.valid           = result_valid_reg;
    assign result.remaining_count = remaining_reg;

    // sequencer is not ready again in the cycle after it takes a pixel beat
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> !pixel.ready)
        else $error("pixel beat taken while previous one still in setup");

    // a pending result never exceeds the iteration limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.remaining_count <= max_iterations_reg)
        else $error("remaining count above iteration limit");

    // a new result is only loaded into a free slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !evt.out_load)
        else $error("result register overwritten while held");

endmodule

[rtl/core/mbet_sequencer.sv]
// mbet_sequencer: step counter over the microprogram rom with conditional jumps.
// depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_sequencer import mbet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_free,
    input  dp_status_t status,
    output ucode_t     ctrl,
    output seq_evt_t   evt
);

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;

    assign ctrl    = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    always_comb
    begin
        evt.in_ready = (ctrl.op == SEQ_WAIT_IN);
        evt.in_take  = (ctrl.op == SEQ_WAIT_IN) && in_valid;
        evt.out_load = (ctrl.op == SEQ_EMIT) && out_free;
    end

    always_comb
    begin
        unique case (ctrl.op)
            SEQ_NEXT:    upc_next = upc_inc;
            SEQ_JUMP:    upc_next = ctrl.target;
            SEQ_EXIT:    upc_next = status.exit_loop ? ctrl.target : upc_inc;
            SEQ_WAIT_IN: upc_next = in_valid ? upc_inc : upc_reg;
            SEQ_EMIT:    upc_next = out_free ? ctrl.target : upc_reg;
            default:     upc_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= S_IDLE;
        else
            upc_reg <= upc_next;
    end

    // last step of an iteration always returns to the loop test
    a_loop_back: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == S_Y2 |=> upc_reg == S_LOOP)
        else $error("iteration did not return to loop test");

endmodule

[rtl/core/mbet_datapath.sv]
// mbet_datapath: shared 32x32 multiplier, saturating adders and the point,
// orbit and count registers. depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_datapath import mbet_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ucode_t                   ctrl,
    input  logic                     capture,
    input  logic [IDX_W-1:0]         column,
    input  logic [IDX_W-1:0]         row,
    input  logic signed [DATA_W-1:0] window_x_min,
    input  logic signed [DATA_W-1:0] window_y_min,
    input  logic [STEP_W-1:0]        step_x,
    input  logic [STEP_W-1:0]        step_y,
    input  logic [CNT_W-1:0]         max_iterations,
    output dp_status_t               status,
    output logic [CNT_W-1:0]         remaining_count
);

    logic [IDX_W-1:0]         col_reg, row_reg;
    logic [IDX_W-1:0]         col_next, row_next;
    logic signed [PROD_W-1:0] p_reg, p_next;
    logic signed [DATA_W-1:0] cx_reg, cy_reg, x_reg, y_reg, x2_reg, y2_reg;
    logic signed [DATA_W-1:0] wb_next, x_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] p_xy, p_sq;
    logic signed [SAT_W-1:0]  add_base, add_term;
    logic signed [DATA_W:0]   mag;

    // index clamp onto the pixel grid
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (capture)
        begin
            col_next = (DATA_W'(column) > DATA_W'(PIXEL_DIM - 1)) ?
                       IDX_W'(PIXEL_DIM - 1) : column;
            row_next = (DATA_W'(row) > DATA_W'(PIXEL_DIM - 1)) ?
                       IDX_W'(PIXEL_DIM - 1) : row;
        end
    end

    // multiplier operand select
    always_comb
    begin
        unique case (ctrl.mul)
            MUL_COLX:
            begin
                mul_a = DATA_W'(col_reg);
                mul_b = {1'b0, step_x};
            end
            MUL_ROWY:
            begin
                mul_a = DATA_W'(row_reg);
                mul_b = {1'b0, step_y};
            end
            MUL_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            MUL_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MUL_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    // 2xy uses one bit less of shift; floor rounding from the arithmetic shift
    assign p_xy = p_reg >>> (FRAC_BITS - 1);
    assign p_sq = p_reg >>> FRAC_BITS;

    always_comb
    begin
        unique case (ctrl.wb)
            WB_CX:
            begin
                add_base = p_reg[SAT_W-1:0];
                add_term = SAT_W'(window_x_min);
            end
            WB_CY:
            begin
                add_base = p_reg[SAT_W-1:0];
                add_term = SAT_W'(window_y_min);
            end
            WB_Y:
            begin
                add_base = p_xy[SAT_W-1:0];
                add_term = SAT_W'(cy_reg);
            end
            WB_X2, WB_Y2:
            begin
                add_base = p_sq[SAT_W-1:0];
                add_term = '0;
            end
            default:
            begin
                add_base = '0;
                add_term = '0;
            end
        endcase
    end

    assign wb_next = sat32(add_base + add_term);
    assign x_next  = sat32(SAT_W'(x2_reg) - SAT_W'(y2_reg) + SAT_W'(cx_reg));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.init)
            cnt_next = '0;
        else if (ctrl.cnt_inc)
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        row_reg <= row_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
        if (ctrl.init)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            x2_reg <= '0;
            y2_reg <= '0;
        end
        else
        begin
            if (ctrl.upd_x)
                x_reg <= x_next;
            unique case (ctrl.wb)
                WB_CX:   cx_reg <= wb_next;
                WB_CY:   cy_reg <= wb_next;
                WB_Y:    y_reg  <= wb_next;
                WB_X2:   x2_reg <= wb_next;
                WB_Y2:   y2_reg <= wb_next;
                default: ;
            endcase
        end
    end

    assign mag              = {x2_reg[DATA_W-1], x2_reg} + {y2_reg[DATA_W-1], y2_reg};
    assign status.exit_loop = (mag > ESC_LIMIT) || (cnt_reg >= max_iterations);
    assign remaining_count  = max_iterations - cnt_reg;

    // squares are floors of non-negative products
    a_sq_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wb == WB_Y2 |=> !x2_reg[DATA_W-1] && !y2_reg[DATA_W-1])
        else $error("negative square in orbit registers");

endmodule
